// ===== sv/bod_pkg.sv =====
package bod_pkg;

    // Defaults for the top-level parameters.
    localparam int ARC_BITS_DEF = 32;
    localparam int MAX_ARCS_DEF = 128;

    // Status codes carried on each result word.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PREFIX   = 3'd1;
    localparam logic [2:0] ST_SHORT    = 3'd2;
    localparam logic [2:0] ST_TRUNC    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_TOOMANY  = 3'd5;

    localparam logic [7:0] PREFIX_LO       = 8'h28;
    localparam logic [7:0] PREFIX_HI       = 8'h2B;
    localparam logic [7:0] FIRST_ARC_BASE  = 8'd40;
    localparam logic [6:0] COUNT_CAP       = 7'd64;
    localparam logic [6:0] MIN_BYTES_RESET = 7'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [31:0] arc_value;
        logic [6:0]  arc_index;
        logic [2:0]  status;
        logic        last_result;
    } t_out_word;

    // Results of one decoded byte: up to two words, in order.
    typedef struct packed {
        logic [1:0] count;
        t_out_word  res0;
        t_out_word  res1;
    } t_step;

endpackage

// ===== sv/ber_oid_decoder.sv =====
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_data  (bod_pkg::t_in_word)
// result    out        o_valid / i_ready    o_data  (bod_pkg::t_out_word)
// config    in         i_cfg_we             i_cfg_data (min_bytes)
//
// One byte is accepted per cycle while the result buffer has space; each byte is
// decoded combinationally from the input register into a two-word result buffer.
// A first byte in the prefix range yields two words and needs an empty buffer:
// with a word still waiting it stalls until that word drains, and a following
// byte that yields a word stalls while the extra word drains.
// Reset is synchronous and active low; it clears the decoder state and sets
// min_bytes to one.
module ber_oid_decoder #(
    parameter int ARC_BITS = bod_pkg::ARC_BITS_DEF,
    parameter int MAX_ARCS = bod_pkg::MAX_ARCS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bod_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output bod_pkg::t_out_word o_data,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data
);

    logic              held;
    logic              space;
    logic              advance;
    bod_pkg::t_in_word word;
    bod_pkg::t_step    step;

    assign advance = held && space;

    bod_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .i_advance (advance),
        .o_held    (held),
        .o_word    (word)
    );

    bod_decode #(
        .ARC_BITS (ARC_BITS),
        .MAX_ARCS (MAX_ARCS)
    ) u_dec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_word     (word),
        .i_advance  (advance),
        .o_step     (step)
    );

    bod_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_push  (advance),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

// ===== sv/bod_in_reg.sv =====
module bod_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  bod_pkg::t_in_word i_data,
    input  logic              i_advance,
    output logic              o_held,
    output bod_pkg::t_in_word o_word
);

    logic              r_valid;
    bod_pkg::t_in_word r_word;

    assign o_ready = !r_valid || i_advance;
    assign o_held  = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_data;
        end
    end

endmodule

// ===== sv/bod_decode.sv =====
module bod_decode #(
    parameter int ARC_BITS = bod_pkg::ARC_BITS_DEF,
    parameter int MAX_ARCS = bod_pkg::MAX_ARCS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [6:0]        i_cfg_data,
    input  bod_pkg::t_in_word i_word,
    input  logic              i_advance,
    output bod_pkg::t_step    o_step
);

    localparam int CNT_W = $clog2(MAX_ARCS + 1);
    localparam logic [CNT_W-1:0] ARC_LIMIT = CNT_W'(MAX_ARCS);
    localparam logic [CNT_W-1:0] TWO_ARCS  = CNT_W'(2);

    logic [ARC_BITS-1:0] r_acc, n_acc;
    logic                r_pend, n_pend;
    logic [6:0]          r_bytes, n_bytes;
    logic [CNT_W-1:0]    r_arcs, n_arcs;
    logic [2:0]          r_err, n_err;
    logic [6:0]          r_min_bytes;

    logic                first;
    logic [ARC_BITS-1:0] shifted;
    logic [2:0]          status;
    bod_pkg::t_step      step;

    always_comb begin
        first   = i_word.first_byte || (r_bytes == 7'd0);
        n_acc   = first ? '0 : r_acc;
        n_pend  = first ? 1'b0 : r_pend;
        n_arcs  = first ? '0 : r_arcs;
        n_err   = first ? bod_pkg::ST_OK : r_err;
        n_bytes = first ? 7'd0 : r_bytes;
        if (n_bytes < bod_pkg::COUNT_CAP) begin
            n_bytes = n_bytes + 7'd1;
        end
        shifted = {n_acc[ARC_BITS-8:0], i_word.data_byte[6:0]};
        status  = bod_pkg::ST_OK;

        step       = '0;
        step.res0.status = bod_pkg::ST_OK;
        step.res1.status = bod_pkg::ST_OK;

        if (first) begin
            // The first byte folds the two leading arcs; only arc one is legal here.
            if (i_word.data_byte >= bod_pkg::PREFIX_LO &&
                i_word.data_byte <= bod_pkg::PREFIX_HI) begin
                step.count          = 2'd2;
                step.res0.arc_value = 32'd1;
                step.res0.arc_index = 7'd0;
                step.res1.arc_value = 32'(i_word.data_byte - bod_pkg::FIRST_ARC_BASE);
                step.res1.arc_index = 7'd1;
                n_arcs              = TWO_ARCS;
            end else begin
                n_err = bod_pkg::ST_PREFIX;
            end
        end else if (n_err == bod_pkg::ST_OK) begin
            if (n_acc[ARC_BITS-1 -: 7] != 7'd0) begin
                n_err = bod_pkg::ST_OVERFLOW;
            end else begin
                n_acc = shifted;
                if (i_word.data_byte[7]) begin
                    n_pend = 1'b1;
                end else if (n_arcs >= ARC_LIMIT) begin
                    n_err = bod_pkg::ST_TOOMANY;
                end else begin
                    step.count          = 2'd1;
                    step.res0.arc_value = 32'(shifted);
                    step.res0.arc_index = 7'(n_arcs);
                    n_arcs              = n_arcs + CNT_W'(1);
                    n_acc               = '0;
                    n_pend              = 1'b0;
                end
            end
        end

        if (n_err != bod_pkg::ST_OK) begin
            step.count = 2'd0;
        end

        if (i_word.last_byte) begin
            if (n_bytes < r_min_bytes) begin
                status = bod_pkg::ST_SHORT;
            end else if (n_err != bod_pkg::ST_OK) begin
                status = n_err;
            end else if (n_pend) begin
                status = bod_pkg::ST_TRUNC;
            end else begin
                status = bod_pkg::ST_OK;
            end

            if (status != bod_pkg::ST_OK || step.count == 2'd0) begin
                step.count       = 2'd1;
                step.res0        = '0;
                step.res0.status = status;
                step.res0.last_result = 1'b1;
            end else if (step.count == 2'd2) begin
                step.res1.last_result = 1'b1;
            end else begin
                step.res0.last_result = 1'b1;
            end

            n_acc   = '0;
            n_pend  = 1'b0;
            n_bytes = 7'd0;
            n_arcs  = '0;
            n_err   = bod_pkg::ST_OK;
        end
    end

    assign o_step = step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_pend  <= 1'b0;
            r_bytes <= 7'd0;
            r_arcs  <= '0;
            r_err   <= bod_pkg::ST_OK;
        end else if (i_advance) begin
            r_acc   <= n_acc;
            r_pend  <= n_pend;
            r_bytes <= n_bytes;
            r_arcs  <= n_arcs;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bytes <= bod_pkg::MIN_BYTES_RESET;
        end else if (i_cfg_we) begin
            r_min_bytes <= i_cfg_data;
        end
    end

endmodule

// ===== sv/bod_out_buf.sv =====
module bod_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bod_pkg::t_step     i_step,
    input  logic               i_push,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output bod_pkg::t_out_word o_data
);

    bod_pkg::t_out_word r_slot [2];
    bod_pkg::t_out_word n_slot [2];
    logic [1:0]         r_occ, n_occ;
    logic               pop;

    // Space is judged before this cycle's pop so that ready does not depend on
    // the downstream ready.
    assign o_space = ({1'b0, r_occ} + {1'b0, i_step.count}) <= 3'd2;
    assign o_valid = r_occ != 2'd0;
    assign o_data  = r_slot[0];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_slot[0] = r_slot[0];
        n_slot[1] = r_slot[1];
        n_occ     = r_occ;
        if (pop) begin
            n_slot[0] = r_slot[1];
            n_occ     = r_occ - 2'd1;
        end
        if (i_push) begin
            case (n_occ)
                2'd0: begin
                    n_slot[0] = i_step.res0;
                    n_slot[1] = i_step.res1;
                end
                2'd1: begin
                    n_slot[1] = i_step.res0;
                end
                default: begin
                end
            endcase
            n_occ = n_occ + i_step.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 2'd0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot[0] <= n_slot[0];
        r_slot[1] <= n_slot[1];
    end

endmodule

// ===== sv/bod_checker.sv =====
module bod_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input bod_pkg::t_out_word o_data
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.status <= bod_pkg::ST_TOOMANY)
        else $error("undefined status code");

    // An error word is the closing word of its identifier and carries no arc.
    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != bod_pkg::ST_OK |->
            o_data.last_result && o_data.arc_value == 32'd0 && o_data.arc_index == 7'd0)
        else $error("malformed error word");

endmodule

bind ber_oid_decoder bod_checker u_bod_checker (.*);
